>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each clock edge, skipped while reset is low
`define BFI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each clock edge, reset included
`define BFI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bfi_pkg.sv
package bfi_pkg;

  // Default sizing
  localparam int MAX_HASHES_DEF      = 16;
  localparam int BIT_STORE_DEPTH_DEF = 65536;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int ADDRESS_W  = 32;
  localparam int COEF_H_W   = 4;
  localparam int COEF_O_W   = 2;
  localparam int COEF_W     = 64;
  localparam int HASHES_W   = 5;
  localparam int TSIZE_W    = 17;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OCTET_W    = 8;
  localparam int WORD_BITS  = 64;

  localparam logic [OCTET_W-1:0] OCTET_MASK = 8'hFF;

  // Remainder digits retired per cycle by the modulo unit
  localparam int MOD_STEPS = 4;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  // Register indexes
  localparam logic REG_HASHES     = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  // Register reset values
  localparam logic [HASHES_W-1:0] HASHES_RST = 5'd14;
  localparam logic [TSIZE_W-1:0]  TSIZE_RST  = 17'd20011;

  // Modulo unit status
  typedef struct packed {
    logic busy;
    logic done;
  } bfi_mod_stat_t;

endpackage

>>> rtl/core/bfi_if.sv
interface bfi_in_if;
  import bfi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [ADDRESS_W-1:0]  address;
  logic [COEF_H_W-1:0]   coef_hash;
  logic [COEF_O_W-1:0]   coef_octet;
  logic [COEF_W-1:0]     coef_value;

  modport source(output valid, action, address, coef_hash, coef_octet, coef_value,
                 input ready);
  modport sink(input valid, action, address, coef_hash, coef_octet, coef_value,
               output ready);
endinterface

interface bfi_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source(output valid, found, input ready);
  modport sink(input valid, found, output ready);
endinterface

>>> rtl/core/bfi_ram.sv
module bfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bfi_modr.sv
module bfi_modr #(
  parameter int MW = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bfi_pkg::COEF_W-1:0] dividend,
  input  logic [MW-1:0]              modulus,
  output logic [MW-1:0]              rem,
  output bfi_pkg::bfi_mod_stat_t     stat
);
  import bfi_pkg::*;

  localparam int ROUNDS = COEF_W / MOD_STEPS;
  localparam int CW = $clog2(ROUNDS + 1);

  logic [COEF_W-1:0] quo_r, quo_nxt;
  logic [MW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // Retire MOD_STEPS dividend bits per cycle, restoring style
  always_comb begin
    logic [MW:0] t;
    logic [MW-1:0] r;
    r = rem_r;
    for (int i = 0; i < MOD_STEPS; i++) begin
      t = {r, quo_r[COEF_W-1-i]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      r = t[MW-1:0];
    end
    quo_nxt  = quo_r << MOD_STEPS;
    rem_nxt  = r;
    cnt_nxt  = cnt_r - CW'(1);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(ROUNDS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      quo_nxt = quo_r;
      rem_nxt = rem_r;
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/core/bloom_filter_ipv4.sv
// Bloom filter over IPv4 addresses. After reset the block sweeps the bit store to zero, one
// 64-bit word per cycle, and takes no item meanwhile; register writes are taken at all times.
// A load transfer writes one coefficient when its hash index is below MAX_HASHES, and yields
// a result. An insert or lookup with n hashes in use works, per hash, through four coefficient
// reads and multiply-adds (states S_CRD and S_MAC in turn, one coefficient memory port), the
// modulo unit that retires four dividend bits a cycle and hands back the remainder, and a read
// of one bit-store word, which an insert writes back with the bit set.
// Each result is one transfer whose found bit is set only for a lookup that hit.
module bloom_filter_ipv4 #(
  parameter int MAX_HASHES      = bfi_pkg::MAX_HASHES_DEF,
  parameter int BIT_STORE_DEPTH = bfi_pkg::BIT_STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bfi_in_if.sink                         in_ch,
  bfi_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bfi_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bfi_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bfi_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import bfi_pkg::*;

  localparam int COEF_DEPTH = MAX_HASHES * 4;
  localparam int CW    = $clog2(COEF_DEPTH);
  localparam int HW    = $clog2(MAX_HASHES + 1);
  localparam int MW    = $clog2(BIT_STORE_DEPTH + 1);
  localparam int WORDS = (BIT_STORE_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_BRD  = 3'd5;
  localparam logic [2:0] S_BUPD = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [HASHES_W-1:0]  hashes_r;
  logic [TSIZE_W-1:0]   tsize_r;
  logic [ACTION_W-1:0]  act_r, act_nxt;
  logic [ADDRESS_W-1:0] addr_r, addr_nxt;
  logic [HW-1:0]        n_r, n_nxt, n_c;
  logic [HW-1:0]        j_r, j_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [COEF_W-1:0]    acc_r, acc_nxt, mac_sum;
  logic                 all_r, all_nxt;
  logic [WW-1:0]        clr_r, clr_nxt;
  logic                 ov_r, ov_nxt;
  logic                 of_r, of_nxt;
  logic [MW-1:0]        m_c;
  logic [OCTET_W-1:0]   oct;
  logic                 in_xfer;

  logic              cram_we;
  logic [CW-1:0]     cram_waddr, cram_raddr;
  logic [COEF_W-1:0] cram_rdata;

  logic                 bram_we;
  logic [WW-1:0]        bram_waddr, bram_raddr;
  logic [WORD_BITS-1:0] bram_wdata, bram_rdata;

  logic          mod_start;
  logic [MW-1:0] mod_rem;
  bfi_mod_stat_t mod_stat;
  logic [5:0]    bpos;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TABLE_SIZE) ? CFG_DATA_W'(tsize_r)
                                                       : CFG_DATA_W'(hashes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hashes_r <= HASHES_RST;
      tsize_r  <= TSIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_HASHES) begin
        hashes_r <= cfg_pwdata[HASHES_W-1:0];
      end else begin
        tsize_r <= cfg_pwdata[TSIZE_W-1:0];
      end
    end
  end

  // Clamp hash count and modulus
  assign n_c = (32'(hashes_r) > 32'(MAX_HASHES)) ? HW'(MAX_HASHES) : HW'(hashes_r);
  always_comb begin
    if (tsize_r == '0) begin
      m_c = MW'(1);
    end else if (32'(tsize_r) > 32'(BIT_STORE_DEPTH)) begin
      m_c = MW'(BIT_STORE_DEPTH);
    end else begin
      m_c = MW'(tsize_r);
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Coefficient memory: written on load, read per octet
  assign cram_we    = in_xfer && (in_ch.action == ACT_LOAD) &&
                      (32'(in_ch.coef_hash) < 32'(MAX_HASHES));
  assign cram_waddr = CW'(32'(in_ch.coef_hash) * 4 + 32'(in_ch.coef_octet));
  assign cram_raddr = CW'(32'(j_r) * 4 + 32'(k_r));

  bfi_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk(clk), .we(cram_we), .waddr(cram_waddr), .wdata(in_ch.coef_value),
    .raddr(cram_raddr), .rdata(cram_rdata)
  );

  // Multiply-add of one octet
  assign oct     = OCTET_W'(addr_r >> (5'd24 - {k_r, 3'b000})) & OCTET_MASK;
  assign mac_sum = acc_r + cram_rdata * COEF_W'(oct);

  assign mod_start = (state_r == S_MAC) && (k_r == 2'd3);

  bfi_modr #(.MW(MW)) u_modr (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mac_sum),
    .modulus(m_c), .rem(mod_rem), .stat(mod_stat)
  );

  // Bit store: clear sweep, or on insert set one bit in the word read back
  assign bpos       = mod_rem[5:0];
  assign bram_raddr = WW'(mod_rem >> 6);
  always_comb begin
    bram_we    = 1'b0;
    bram_waddr = bram_raddr;
    bram_wdata = bram_rdata | (WORD_BITS'(1) << bpos);
    if (state_r == S_CLR) begin
      bram_we    = 1'b1;
      bram_waddr = clr_r;
      bram_wdata = '0;
    end else if (state_r == S_BUPD && act_r == ACT_INSERT) begin
      bram_we = 1'b1;
    end
  end

  bfi_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_bit_ram (
    .clk(clk), .we(bram_we), .waddr(bram_waddr), .wdata(bram_wdata),
    .raddr(bram_raddr), .rdata(bram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    addr_nxt  = addr_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    all_nxt   = all_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r;
    of_nxt    = of_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + WW'(1);
        if (32'(clr_r) == WORDS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt  = in_ch.action;
          addr_nxt = in_ch.address;
          n_nxt    = n_c;
          j_nxt    = '0;
          k_nxt    = '0;
          acc_nxt  = '0;
          all_nxt  = 1'b1;
          if ((in_ch.action == ACT_INSERT || in_ch.action == ACT_LOOKUP) && n_c != '0) begin
            state_nxt = S_CRD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CRD: state_nxt = S_MAC;
      S_MAC: begin
        acc_nxt = mac_sum;
        k_nxt   = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_DIV : S_CRD;
      end
      S_DIV: begin
        if (mod_stat.done) begin
          state_nxt = S_BRD;
        end
      end
      S_BRD: state_nxt = S_BUPD;
      S_BUPD: begin
        if (!bram_rdata[bpos]) begin
          all_nxt = 1'b0;
        end
        j_nxt   = j_r + HW'(1);
        k_nxt   = '0;
        acc_nxt = '0;
        state_nxt = (j_r + HW'(1) == n_r) ? S_FIN : S_CRD;
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = (act_r == ACT_LOOKUP) && all_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    act_r  <= act_nxt;
    addr_r <= addr_nxt;
    n_r    <= n_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    all_r  <= all_nxt;
    of_r   <= of_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.found = of_r;

endmodule

>>> rtl/core/bfi_checker.sv
`include "assert_macros.svh"

module bfi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic cfg_pready
);

  // Clear sweep blocks input right after reset
  `BFI_ASSERT_ALWAYS(a_clr_after_rst, clk, rst_n && !$past(rst_n) |-> !in_ready, "input open during clear")
  // Register port never stalls
  `BFI_ASSERT(a_pready, clk, rst_n, cfg_pready, "pready low")
  // Pending result holds
  `BFI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `BFI_ASSERT(a_found_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_found), "found changed while stalled")

endmodule

bind bloom_filter_ipv4 bfi_checker u_bfi_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_found(out_ch.found), .cfg_pready(cfg_pready)
);
